// File: rtl/febp_pkg.sv
// Erase block planner package: item, result and configuration types and codes.
// No dependencies; used by every module of the planner.
`default_nettype none

package febp_pkg;

    // Flash geometry
    localparam int unsigned SECTOR_SHIFT   = 12;
    localparam int unsigned ADDR_W         = 24;
    localparam int unsigned COUNT_W        = 16;
    localparam int unsigned SECTORS_W      = 5;
    localparam logic [SECTORS_W-1:0] SECTORS_SMALL  = 5'd1;
    localparam logic [SECTORS_W-1:0] SECTORS_MEDIUM = 5'd8;
    localparam logic [SECTORS_W-1:0] SECTORS_LARGE  = 5'd16;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_READY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ISSUED     = 2'd0;
    localparam logic [1:0] ST_DONE       = 2'd1;
    localparam logic [1:0] ST_MISALIGNED = 2'd2;
    localparam logic [1:0] ST_BUSY       = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_OP_SMALL  = 2'd0;
    localparam logic [1:0] CFG_OP_MEDIUM = 2'd1;
    localparam logic [1:0] CFG_OP_LARGE  = 2'd2;

    localparam logic [7:0] OP_SMALL_RESET = 8'h20;

    typedef struct packed {
        logic               cmd;
        logic [ADDR_W-1:0]  start_address;
        logic [COUNT_W-1:0] sector_count;
    } item_t;

    typedef struct packed {
        logic [7:0] op_small;
        logic [7:0] op_medium;
        logic [7:0] op_large;
    } cfg_t;

    typedef struct packed {
        logic                 has_result;
        logic [1:0]           status;
        logic [7:0]           opcode;
        logic [ADDR_W-1:0]    address;
        logic [SECTORS_W-1:0] sectors;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/febp_step.sv
// Erase block planner decision logic: one word in, job state update and result out.
// Purely combinational; depends on febp_pkg.
`default_nettype none

module febp_step #(
    parameter int unsigned ADDRESS_BITS = 24
) (
    input  febp_pkg::item_t                item,
    input  febp_pkg::cfg_t                 cfg,
    input  logic                           active,
    input  logic [ADDRESS_BITS-1:0]        addr,
    input  logic [febp_pkg::COUNT_W-1:0]   left,
    output logic                           active_next,
    output logic [ADDRESS_BITS-1:0]        addr_next,
    output logic [febp_pkg::COUNT_W-1:0]   left_next,
    output febp_pkg::result_t              result
);
    import febp_pkg::*;

    logic                    issue;
    logic [ADDRESS_BITS-1:0] base;
    logic [COUNT_W-1:0]      base_left;
    logic [ADDRESS_BITS-1:0] in_addr;
    logic                    use_large;
    logic                    use_medium;
    logic [SECTORS_W-1:0]    cmd_sectors;
    logic [7:0]              cmd_opcode;
    logic [ADDRESS_BITS-1:0] step_bytes;

    assign in_addr = item.start_address[ADDRESS_BITS-1:0];

    // Pick the block to erase from the job start or the running job
    always_comb
    begin
        issue       = 1'b0;
        active_next = active;
        base        = addr;
        base_left   = left;
        result      = '0;
        if (item.cmd == CMD_START) begin
            result.has_result = 1'b1;
            if (active) begin
                result.status = ST_BUSY;
            end else if (in_addr[SECTOR_SHIFT-1:0] != '0) begin
                result.status = ST_MISALIGNED;
            end else if (item.sector_count == '0) begin
                result.status = ST_DONE;
            end else begin
                issue       = 1'b1;
                active_next = 1'b1;
                base        = in_addr;
                base_left   = item.sector_count;
            end
        end else if (active) begin
            result.has_result = 1'b1;
            if (left == '0) begin
                active_next   = 1'b0;
                result.status = ST_DONE;
            end else begin
                issue = 1'b1;
            end
        end
        if (issue) begin
            result.status  = ST_ISSUED;
            result.opcode  = cmd_opcode;
            result.address = ADDR_W'(base);
            result.sectors = cmd_sectors;
        end
    end

    // Largest block that fits the alignment, the remaining count and the opcodes
    assign use_large  = (base_left >= COUNT_W'(SECTORS_LARGE)) && (base[15:0] == '0)
                        && (cfg.op_large != '0);
    assign use_medium = (base_left >= COUNT_W'(SECTORS_MEDIUM)) && (base[14:0] == '0)
                        && (cfg.op_medium != '0);

    always_comb
    begin
        if (use_large) begin
            cmd_opcode  = cfg.op_large;
            cmd_sectors = SECTORS_LARGE;
        end else if (use_medium) begin
            cmd_opcode  = cfg.op_medium;
            cmd_sectors = SECTORS_MEDIUM;
        end else begin
            cmd_opcode  = cfg.op_small;
            cmd_sectors = SECTORS_SMALL;
        end
    end

    // Advance address and count past the issued block, wrapping the address
    assign step_bytes = ADDRESS_BITS'({cmd_sectors, {SECTOR_SHIFT{1'b0}}});
    assign addr_next  = issue ? (base + step_bytes) : addr;
    assign left_next  = issue ? (base_left - COUNT_W'(cmd_sectors)) : left;

endmodule

`default_nettype wire

// File: rtl/flash_erase_block_planner_core.sv
// An accepted word is held in the input register and its result is then loaded
// into the result register, where it waits until it is taken.
// Throughput: one word per cycle unless the result is stalled; the input register
// drains whenever the result register is empty or being taken in the same cycle.
// A ready word while idle gives no result. Configuration writes are always taken.
// Reset (rst_n low, asynchronous) empties both stages, idles the job and
// loads the opcode registers with their reset values.
`default_nettype none

module flash_erase_block_planner_core #(
    parameter int unsigned ADDRESS_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [febp_pkg::ADDR_W-1:0]     start_address,
    input  logic [febp_pkg::COUNT_W-1:0]    sector_count,
    // result words
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [7:0]                      erase_opcode,
    output logic [febp_pkg::ADDR_W-1:0]     erase_address,
    output logic [febp_pkg::SECTORS_W-1:0]  erase_sectors,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data
);
    import febp_pkg::*;

    logic                    s1_valid_reg;
    item_t                   s1_item_reg;
    cfg_t                    cfg_reg;
    logic                    job_active_reg;
    logic                    job_active_next;
    logic [ADDRESS_BITS-1:0] next_address_reg;
    logic [ADDRESS_BITS-1:0] next_address_next;
    logic [COUNT_W-1:0]      sectors_left_reg;
    logic [COUNT_W-1:0]      sectors_left_next;
    result_t                 step_result;
    result_t                 out_reg;
    logic                    out_valid_reg;
    logic                    advance;
    logic                    out_free;

    // Move the held word on when the result slot is free or being emptied
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s1_item_reg <= '{cmd: cmd, start_address: start_address,
                             sector_count: sector_count};
        end
    end

    // Opcode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.op_small  <= OP_SMALL_RESET;
            cfg_reg.op_medium <= '0;
            cfg_reg.op_large  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OP_SMALL:  cfg_reg.op_small  <= cfg_data;
                CFG_OP_MEDIUM: cfg_reg.op_medium <= cfg_data;
                CFG_OP_LARGE:  cfg_reg.op_large  <= cfg_data;
                default: ;
            endcase
        end
    end

    febp_step #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_step (
        .item        (s1_item_reg),
        .cfg         (cfg_reg),
        .active      (job_active_reg),
        .addr        (next_address_reg),
        .left        (sectors_left_reg),
        .active_next (job_active_next),
        .addr_next   (next_address_next),
        .left_next   (sectors_left_next),
        .result      (step_result)
    );

    // Update the job state as the word passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_active_reg   <= 1'b0;
            next_address_reg <= '0;
            sectors_left_reg <= '0;
        end else if (advance) begin
            job_active_reg   <= job_active_next;
            next_address_reg <= next_address_next;
            sectors_left_reg <= sectors_left_next;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && step_result.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_result.has_result) begin
            out_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign erase_opcode  = out_reg.opcode;
    assign erase_address = out_reg.address;
    assign erase_sectors = out_reg.sectors;

endmodule

`default_nettype wire

// File: rtl/febp_checker.sv
// Port-level checks for the erase block planner, bound to the top level.
// Depends on febp_pkg and flash_erase_block_planner_core.
`default_nettype none

module febp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            cmd,
    input  logic [febp_pkg::ADDR_W-1:0]     start_address,
    input  logic [febp_pkg::COUNT_W-1:0]    sector_count,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      status,
    input  logic [7:0]                      erase_opcode,
    input  logic [febp_pkg::ADDR_W-1:0]     erase_address,
    input  logic [febp_pkg::SECTORS_W-1:0]  erase_sectors,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data
);
    import febp_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
        && $stable(erase_address) && $stable(erase_sectors) && $stable(erase_opcode))
        else $error("stalled result word changed");

    // Non-issue results carry an empty command
    a_empty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_ISSUED |->
        erase_opcode == '0 && erase_address == '0 && erase_sectors == '0)
        else $error("status word carries command fields");

    // Issued commands cover 1, 8 or 16 sectors
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ISSUED |->
        erase_sectors == SECTORS_SMALL || erase_sectors == SECTORS_MEDIUM
        || erase_sectors == SECTORS_LARGE)
        else $error("bad erase size");

    // Issued addresses are aligned to their block size
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ISSUED |->
        erase_address[11:0] == '0
        && (erase_sectors != SECTORS_MEDIUM || erase_address[14:0] == '0)
        && (erase_sectors != SECTORS_LARGE || erase_address[15:0] == '0))
        else $error("misaligned erase address");

endmodule

bind flash_erase_block_planner_core febp_checker u_febp_checker (.*);

`default_nettype wire

// File: tb/sv/flash_erase_block_planner_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the flash erase block planner core: directed erase jobs,
// then random jobs under changing opcode settings. Needs febp_pkg and the core RTL.

import febp_pkg::*;

typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           opcode;
    logic [ADDR_W-1:0]    address;
    logic [SECTORS_W-1:0] sectors;
} erase_word_t;

class erase_plan_scoreboard;
    logic [7:0]         op_small;
    logic [7:0]         op_medium;
    logic [7:0]         op_large;
    bit                 job_active;
    logic [ADDR_W-1:0]  next_addr;
    logic [COUNT_W-1:0] sectors_left;
    erase_word_t        erase_words_q[$];
    int                 errors;

    function new();
        op_small     = OP_SMALL_RESET;
        op_medium    = 8'h00;
        op_large     = 8'h00;
        job_active   = 1'b0;
        next_addr    = '0;
        sectors_left = '0;
        errors       = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [7:0] data);
        case (idx)
            CFG_OP_SMALL:  op_small  = data;
            CFG_OP_MEDIUM: op_medium = data;
            CFG_OP_LARGE:  op_large  = data;
            default: ;
        endcase
    endfunction

    function void push_word(logic [1:0] st, logic [7:0] op, logic [ADDR_W-1:0] ad,
                            logic [SECTORS_W-1:0] se);
        erase_word_t w;
        w.status  = st;
        w.opcode  = op;
        w.address = ad;
        w.sectors = se;
        erase_words_q.push_back(w);
    endfunction

    // Pick the largest block that fits, then advance the job
    function void plan_next();
        logic [7:0]           op;
        logic [SECTORS_W-1:0] n;
        if (sectors_left >= 16 && next_addr[15:0] == 16'h0 && op_large != 8'h00) begin
            op = op_large;
            n  = SECTORS_LARGE;
        end
        else if (sectors_left >= 8 && next_addr[14:0] == 15'h0 && op_medium != 8'h00) begin
            op = op_medium;
            n  = SECTORS_MEDIUM;
        end
        else begin
            op = op_small;
            n  = SECTORS_SMALL;
        end
        push_word(ST_ISSUED, op, next_addr, n);
        next_addr    = next_addr + (ADDR_W'(n) << SECTOR_SHIFT);
        sectors_left = sectors_left - COUNT_W'(n);
    endfunction

    // Note an accepted input word and queue the result it causes, if any
    function void note_word(logic c, logic [ADDR_W-1:0] a, logic [COUNT_W-1:0] n);
        if (c == CMD_START) begin
            if (job_active)
                push_word(ST_BUSY, 8'h00, '0, '0);
            else if (a[11:0] != 12'h0)
                push_word(ST_MISALIGNED, 8'h00, '0, '0);
            else if (n == '0)
                push_word(ST_DONE, 8'h00, '0, '0);
            else begin
                job_active   = 1'b1;
                next_addr    = a;
                sectors_left = n;
                plan_next();
            end
        end
        else if (job_active) begin
            if (sectors_left == '0) begin
                job_active = 1'b0;
                push_word(ST_DONE, 8'h00, '0, '0);
            end
            else
                plan_next();
        end
    endfunction

    // Compare an accepted result word with the oldest expectation
    function void check_word(logic [1:0] st, logic [7:0] op, logic [ADDR_W-1:0] ad,
                             logic [SECTORS_W-1:0] se);
        erase_word_t w;
        if (erase_words_q.size() == 0) begin
            $display("%0t: unexpected result word, status %0d", $time, st);
            errors++;
            return;
        end
        w = erase_words_q.pop_front();
        if (st !== w.status) begin
            $display("%0t: status expected %0d, got %0d", $time, w.status, st);
            errors++;
        end
        if (op !== w.opcode) begin
            $display("%0t: erase_opcode expected %h, got %h", $time, w.opcode, op);
            errors++;
        end
        if (ad !== w.address) begin
            $display("%0t: erase_address expected %h, got %h", $time, w.address, ad);
            errors++;
        end
        if (se !== w.sectors) begin
            $display("%0t: erase_sectors expected %0d, got %0d", $time, w.sectors, se);
            errors++;
        end
    endfunction

    function int pending();
        return erase_words_q.size();
    endfunction

    function bit busy();
        return job_active;
    endfunction
endclass

module flash_erase_block_planner_core_tb;

    localparam int CYCLE_LIMIT = 100000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [ADDR_W-1:0]    start_address;
    logic [COUNT_W-1:0]   sector_count;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           status;
    logic [7:0]           erase_opcode;
    logic [ADDR_W-1:0]    erase_address;
    logic [SECTORS_W-1:0] erase_sectors;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [7:0]           cfg_data;

    erase_plan_scoreboard plan_sb;
    bit                   steady;
    int                   words_sent;
    int                   cycles;

    flash_erase_block_planner_core dut (.*);

    always #4 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one input word after a random gap, hold it until taken
    task automatic send_word(input logic c, input logic [ADDR_W-1:0] a,
                             input logic [COUNT_W-1:0] n);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        start_address <= a;
        sector_count  <= n;
        do @(posedge clk); while (in_stall !== 1'b0);
        if (!(c == CMD_READY && !plan_sb.busy()))
            words_sent++;
        plan_sb.note_word(c, a, n);
    endtask

    // Acknowledge commands until the running job reports done
    task automatic finish_job();
        while (plan_sb.busy())
            send_word(CMD_READY, ADDR_W'($urandom), COUNT_W'($urandom));
    endtask

    // Stop sending and wait until every expected word is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (plan_sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three opcode registers back to back
    task automatic program_opcodes(input logic [7:0] op_s, input logic [7:0] op_m,
                                   input logic [7:0] op_l);
        logic [7:0] vals [3];
        vals[0] = op_s;
        vals[1] = op_m;
        vals[2] = op_l;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            plan_sb.write_register(2'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    // Aligned start address, biased toward block boundaries and the top of memory
    function automatic logic [ADDR_W-1:0] aligned_address();
        case ($urandom_range(0, 3))
            0:       return ADDR_W'($urandom_range(0, 255)) << 16;
            1:       return ADDR_W'($urandom_range(0, 511)) << 15;
            2:       return ADDR_W'($urandom_range(0, 4095)) << 12;
            default: return 24'hFF0000 | (ADDR_W'($urandom_range(0, 15)) << 12);
        endcase
    endfunction

    // Take result words with random stall
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            plan_sb.check_word(status, erase_opcode, erase_address, erase_sectors);
        end
    end

    // Reset, directed jobs, then random phases
    initial
    begin
        logic [ADDR_W-1:0]  a;
        logic [COUNT_W-1:0] n;
        int                 target;

        plan_sb       = new();
        steady        = 1'b0;
        words_sent    = 0;
        cycles        = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_START;
        start_address <= '0;
        sector_count  <= '0;
        out_stall     <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_OP_SMALL;
        cfg_data      <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset opcodes: ready while idle, misaligned before zero count, wrap, busy
        send_word(CMD_READY, 24'hFFFFFF, 16'hFFFF);
        send_word(CMD_START, 24'h000001, 16'hFFFF);
        send_word(CMD_START, 24'hFFFFFF, 16'h0000);
        send_word(CMD_START, 24'h000000, 16'h0000);
        send_word(CMD_START, 24'hFFF000, 16'd2);
        finish_job();
        send_word(CMD_START, 24'h000000, 16'd1);
        send_word(CMD_START, 24'hFFF000, 16'hFFFF);
        finish_job();

        // No 64K opcode, zero 4K opcode: 32K then 4K
        wait_drained();
        program_opcodes(8'h00, 8'hFF, 8'h00);
        send_word(CMD_START, 24'h010000, 16'd9);
        finish_job();

        // All sizes, crossing the top of the address space
        wait_drained();
        program_opcodes(8'h20, 8'h52, 8'hD8);
        send_word(CMD_START, 24'hFF0000, 16'd25);
        finish_job();

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            program_opcodes(pick_opcode(), pick_opcode(), pick_opcode());
            steady = (phase % 3 == 2);
            target = words_sent + 105;
            while (words_sent < target)
            begin
                if (plan_sb.busy())
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_word(CMD_START, ADDR_W'($urandom), COUNT_W'($urandom));
                    else
                        send_word(CMD_READY, ADDR_W'($urandom), COUNT_W'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0: send_word(CMD_READY, ADDR_W'($urandom), COUNT_W'($urandom));
                        1:
                        begin
                            a = ADDR_W'($urandom);
                            a[11:0] = 12'($urandom_range(1, 4095));
                            send_word(CMD_START, a, COUNT_W'($urandom));
                        end
                        2: send_word(CMD_START, aligned_address(), 16'h0000);
                        default:
                        begin
                            n = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom_range(41, 300))
                                                             : COUNT_W'($urandom_range(1, 40));
                            send_word(CMD_START, aligned_address(), n);
                        end
                    endcase
                end
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (plan_sb.errors == 0 && plan_sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/febp_pkg.sv
rtl/febp_step.sv
rtl/flash_erase_block_planner_core.sv
rtl/febp_checker.sv
tb/sv/flash_erase_block_planner_core_tb.sv
